// ===== rtl/core/cstok_pkg.sv =====
// ----------------------------------------------------------------------------
// cstok_pkg
// Shared types, character codes and classification helpers for the
// character stream tokenizer.
// ----------------------------------------------------------------------------
package cstok_pkg;

    typedef enum logic [3:0] {
        TK_END     = 4'd0,
        TK_INT     = 4'd1,
        TK_IF      = 4'd2,
        TK_IDENT   = 4'd3,
        TK_NUMBER  = 4'd4,
        TK_ASSIGN  = 4'd5,
        TK_EQUAL   = 4'd6,
        TK_PLUS    = 4'd7,
        TK_MINUS   = 4'd8,
        TK_SEMI    = 4'd9,
        TK_LPAREN  = 4'd10,
        TK_RPAREN  = 4'd11,
        TK_LBRACE  = 4'd12,
        TK_RBRACE  = 4'd13,
        TK_UNKNOWN = 4'd14
    } tok_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IDENT = 2'd1,
        MODE_NUM   = 2'd2,
        MODE_EQ    = 2'd3
    } scan_mode_t;

    typedef enum logic [2:0] {
        KW_NONE = 3'd0,
        KW_I    = 3'd1,
        KW_IN   = 3'd2,
        KW_INT  = 3'd3,
        KW_IF   = 3'd4
    } kw_track_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] start;
        logic [7:0]  length;
        logic [7:0]  last_char;
        logic        last_of_run;
    } tok_result_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic tok_kind_t single_kind(input logic [7:0] c);
        tok_kind_t k;
        case (c)
            CH_PLUS:   k = TK_PLUS;
            CH_MINUS:  k = TK_MINUS;
            CH_SEMI:   k = TK_SEMI;
            CH_LPAREN: k = TK_LPAREN;
            CH_RPAREN: k = TK_RPAREN;
            CH_LBRACE: k = TK_LBRACE;
            CH_RBRACE: k = TK_RBRACE;
            default:   k = TK_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic kw_track_t next_track(input kw_track_t t, input logic [7:0] c);
        kw_track_t n;
        n = KW_NONE;
        if (t == KW_I && c == CH_N) begin
            n = KW_IN;
        end else if (t == KW_I && c == CH_F) begin
            n = KW_IF;
        end else if (t == KW_IN && c == CH_T) begin
            n = KW_INT;
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/char_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Streaming lexical tokenizer: one source byte or end mark per transfer in,
// one token per transfer out.
// ----------------------------------------------------------------------------
// Usage: an input transfer is taken every cycle while at least two slots of
// the four-entry result queue are free. Each byte is classified and the
// scanner state updated in the cycle of its transfer, and its results (zero,
// one or two) land in the queue for the next cycle. The result side moves
// one token per cycle while m_ready is high, so the input sustains one byte
// per cycle except where an item closes a pending token and forms its own,
// adding a second result; the result queue drain is the limiting unit.
// ----------------------------------------------------------------------------
module char_stream_tokenizer import cstok_pkg::*; #(
    parameter int unsigned MAX_TOKEN_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [7:0]  s_input_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [7:0]  m_token_length,
    output logic [7:0]  m_token_char,
    output logic        m_last_of_run
);

    logic        in_xfer;
    tok_result_t res0, res1, head;
    logic [1:0]  res_cnt;

    assign in_xfer = s_valid && s_ready;

    cstok_scan #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (in_xfer),
        .func    (s_func),
        .in_char (s_input_char),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    cstok_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_xfer),
        .push_cnt  (res_cnt),
        .push0     (res0),
        .push1     (res1),
        .pop       (m_valid && m_ready),
        .has_room  (s_ready),
        .not_empty (m_valid),
        .head      (head)
    );

    assign m_token_kind   = head.kind;
    assign m_token_start  = head.start;
    assign m_token_length = head.length;
    assign m_token_char   = head.last_char;
    assign m_last_of_run  = head.last_of_run;

endmodule

// ===== rtl/core/cstok_scan.sv =====
// ----------------------------------------------------------------------------
// cstok_scan
// Scanner state and per-byte token logic; yields up to two results per
// accepted item.
// ----------------------------------------------------------------------------
module cstok_scan import cstok_pkg::*; #(
    parameter int unsigned MAX_TOKEN_LEN = 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        accept,
    input  logic        func,
    input  logic [7:0]  in_char,
    output tok_result_t res0,
    output tok_result_t res1,
    output logic [1:0]  res_cnt
);

    localparam logic [7:0] LEN_CAP = (MAX_TOKEN_LEN < 255) ? 8'(MAX_TOKEN_LEN) : 8'd255;

    scan_mode_t  mode_reg, mode_next;
    kw_track_t   track_reg, track_next;
    logic [31:0] pstart_reg, pstart_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  plast_reg, plast_next;
    logic [31:0] pos_reg, pos_next;

    logic        c_ws, c_letter, c_digit, c_eq;
    logic        cont_run, eq_pair, single, flush_valid;
    tok_kind_t   flush_kind;
    tok_result_t flush_tok, end_tok, single_tok, equal_tok;

    always_comb begin
        c_ws        = is_ws(in_char);
        c_letter    = is_letter(in_char);
        c_digit     = is_digit(in_char);
        c_eq        = (in_char == CH_EQ);
        cont_run    = (mode_reg == MODE_IDENT && (c_letter || c_digit))
                   || (mode_reg == MODE_NUM && c_digit);
        eq_pair     = (mode_reg == MODE_EQ) && c_eq;
        single      = !c_ws && !c_letter && !c_digit && !c_eq;
        flush_valid = (mode_reg != MODE_IDLE);
    end

    always_comb begin
        mode_next   = mode_reg;
        track_next  = track_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        plast_next  = plast_reg;
        pos_next    = pos_reg;
        if (accept) begin
            if (func) begin
                mode_next  = MODE_IDLE;
                track_next = KW_NONE;
            end else begin
                pos_next = pos_reg + 32'd1;
                if (cont_run) begin
                    if (mode_reg == MODE_IDENT) begin
                        track_next = next_track(track_reg, in_char);
                    end
                    if (plen_reg < LEN_CAP) begin
                        plen_next = plen_reg + 8'd1;
                    end
                    plast_next = in_char;
                end else begin
                    mode_next  = MODE_IDLE;
                    track_next = KW_NONE;
                    if (!eq_pair && (c_letter || c_digit || c_eq)) begin
                        mode_next   = c_letter ? MODE_IDENT : (c_digit ? MODE_NUM : MODE_EQ);
                        track_next  = (c_letter && in_char == CH_I) ? KW_I : KW_NONE;
                        pstart_next = pos_reg;
                        plen_next   = 8'd1;
                        plast_next  = in_char;
                    end
                end
            end
        end
    end

    always_comb begin
        unique case (mode_reg)
            MODE_IDENT: flush_kind = (track_reg == KW_INT) ? TK_INT
                                   : (track_reg == KW_IF) ? TK_IF : TK_IDENT;
            MODE_NUM:   flush_kind = TK_NUMBER;
            MODE_EQ:    flush_kind = TK_ASSIGN;
            default:    flush_kind = TK_END;
        endcase
        flush_tok  = '{flush_kind, pstart_reg, plen_reg, plast_reg, 1'b0};
        end_tok    = '{TK_END, pos_reg, 8'd0, 8'd0, 1'b1};
        single_tok = '{single_kind(in_char), pos_reg, 8'd1, in_char, 1'b1};
        equal_tok  = '{TK_EQUAL, pstart_reg, 8'd2, in_char, 1'b1};

        res0    = end_tok;
        res1    = end_tok;
        res_cnt = 2'd0;
        if (func) begin
            if (flush_valid) begin
                res0    = flush_tok;
                res_cnt = 2'd2;
            end else begin
                res_cnt = 2'd1;
            end
        end else if (cont_run) begin
            res_cnt = 2'd0;
        end else if (eq_pair) begin
            res0    = equal_tok;
            res_cnt = 2'd1;
        end else if (flush_valid && single) begin
            res0    = flush_tok;
            res1    = single_tok;
            res_cnt = 2'd2;
        end else if (flush_valid) begin
            res0             = flush_tok;
            res0.last_of_run = 1'b1;
            res_cnt          = 2'd1;
        end else if (single) begin
            res0    = single_tok;
            res_cnt = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            track_reg  <= KW_NONE;
            pstart_reg <= '0;
            plen_reg   <= '0;
            plast_reg  <= '0;
            pos_reg    <= '0;
        end else begin
            mode_reg   <= mode_next;
            track_reg  <= track_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            plast_reg  <= plast_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ===== rtl/core/cstok_queue.sv =====
// ----------------------------------------------------------------------------
// cstok_queue
// Four-entry shifting result queue; takes up to two results per cycle,
// hands out one per transfer from the head entry.
// ----------------------------------------------------------------------------
module cstok_queue import cstok_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  logic [1:0]  push_cnt,
    input  tok_result_t push0,
    input  tok_result_t push1,
    input  logic        pop,
    output logic        has_room,
    output logic        not_empty,
    output tok_result_t head
);

    localparam int DEPTH = 4;

    tok_result_t q_reg  [DEPTH];
    tok_result_t q_next [DEPTH];
    logic [2:0]  count_reg, count_next;
    logic [2:0]  base;
    logic [1:0]  add;

    assign has_room  = (count_reg <= 3'd2);
    assign not_empty = (count_reg != 3'd0);
    assign head      = q_reg[0];
    assign add       = push ? push_cnt : 2'd0;
    assign base      = count_reg - {2'b00, pop};

    always_comb begin
        count_next = base + {1'b0, add};
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_slot
        tok_result_t shifted;
        if (i < DEPTH - 1) begin : g_mid
            assign shifted = pop ? q_reg[i+1] : q_reg[i];
        end else begin : g_end
            assign shifted = q_reg[i];
        end
        always_comb begin
            q_next[i] = shifted;
            if (add != 2'd0 && base == 3'(i)) begin
                q_next[i] = push0;
            end else if (add == 2'd2 && base + 3'd1 == 3'(i)) begin
                q_next[i] = push1;
            end
        end
        always_ff @(posedge aclk) begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/cstok_checker.sv =====
// ----------------------------------------------------------------------------
// cstok_checker
// Port-level checks for the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module cstok_checker import cstok_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_token_kind,
    input logic [31:0] m_token_start,
    input logic [7:0]  m_token_length,
    input logic [7:0]  m_token_char,
    input logic        m_last_of_run
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_start) && $stable(m_token_kind))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_end_tok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == TK_END |->
            m_last_of_run && m_token_length == 8'd0 && m_token_char == 8'd0)
        else $error("malformed end token");

    a_fixed_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == TK_INT || m_token_kind == TK_IF
                    || m_token_kind == TK_EQUAL) |->
            ((m_token_kind == TK_INT && m_token_length == 8'd3 && m_token_char == CH_T)
             || (m_token_kind == TK_IF && m_token_length == 8'd2 && m_token_char == CH_F)
             || (m_token_kind == TK_EQUAL && m_token_length == 8'd2
                 && m_token_char == CH_EQ && m_last_of_run)))
        else $error("keyword or equality token has wrong shape");

endmodule

bind char_stream_tokenizer cstok_checker u_cstok_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_token_kind   (m_token_kind),
    .m_token_start  (m_token_start),
    .m_token_length (m_token_length),
    .m_token_char   (m_token_char),
    .m_last_of_run  (m_last_of_run)
);

// ===== test/tb_char_stream_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_char_stream_tokenizer
// Self-checking bench for the streaming tokenizer. A directed source snippet
// is followed by randomly built source text. The text mixes keywords,
// identifiers, numbers, operators, whitespace runs, stray bytes, end marks and
// two overlong tokens. Every accepted byte runs through a scanner model kept
// in the bench. Each token the block emits is checked field by field against
// the oldest predicted token. Both sides idle at random, with one long
// back-pressure stretch on the result side.
// ----------------------------------------------------------------------------
module tb_char_stream_tokenizer import cstok_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int TOK_LEN_MAX  = 255;
    localparam int LEN_CAP      = (TOK_LEN_MAX < 255) ? TOK_LEN_MAX : 255;
    localparam int SOURCE_ITEMS = 1720;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
    } src_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [7:0]  s_input_char = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_token_kind;
    logic [31:0] m_token_start;
    logic [7:0]  m_token_length;
    logic [7:0]  m_token_char;
    logic        m_last_of_run;

    src_item_t   source[$];
    src_item_t   nxt;
    tok_result_t tokens_due[$];
    tok_result_t want;

    scan_mode_t  lex_mode = MODE_IDLE;
    kw_track_t   kw_state = KW_NONE;
    logic [31:0] pend_start = '0;
    logic [7:0]  pend_len = '0;
    logic [7:0]  pend_char = '0;
    logic [31:0] byte_pos = '0;

    int          items_sent = 0;
    int          ends_sent = 0;
    int          tokens_checked = 0;
    int          errors = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    logic [14:0] kinds_seen = '0;

    char_stream_tokenizer #(
        .MAX_TOKEN_LEN(TOK_LEN_MAX)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_input_char  (s_input_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_token_start (m_token_start),
        .m_token_length(m_token_length),
        .m_token_char  (m_token_char),
        .m_last_of_run (m_last_of_run)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic alpha_c(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic digit_c(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic tok_result_t make_tok(input tok_kind_t k, input logic [31:0] st,
                                             input logic [7:0] len, input logic [7:0] c);
        tok_result_t t;
        t.kind        = k;
        t.start       = st;
        t.length      = len;
        t.last_char   = c;
        t.last_of_run = 1'b0;
        return t;
    endfunction

    // Scanner model: advance on one source item, queue the tokens it closes or forms.
    task automatic scan_byte(input logic is_end, input logic [7:0] ch);
        tok_result_t found[$];
        tok_kind_t   k;
        logic        absorbed;
        absorbed = 1'b0;
        if (!is_end) begin
            if (lex_mode == MODE_IDENT && (alpha_c(ch) || digit_c(ch))) begin
                case (kw_state)
                    KW_I:    kw_state = (ch == CH_N) ? KW_IN : (ch == CH_F) ? KW_IF : KW_NONE;
                    KW_IN:   kw_state = (ch == CH_T) ? KW_INT : KW_NONE;
                    default: kw_state = KW_NONE;
                endcase
                absorbed = 1'b1;
            end else if (lex_mode == MODE_NUM && digit_c(ch)) begin
                absorbed = 1'b1;
            end else if (lex_mode == MODE_EQ && ch == CH_EQ) begin
                found.push_back(make_tok(TK_EQUAL, pend_start, 8'd2, ch));
                lex_mode = MODE_IDLE;
                kw_state = KW_NONE;
            end
            if (absorbed) begin
                if (pend_len < LEN_CAP) begin
                    pend_len++;
                end
                pend_char = ch;
            end
        end
        if (!absorbed && found.size() == 0) begin
            if (lex_mode != MODE_IDLE) begin
                case (lex_mode)
                    MODE_IDENT: k = (kw_state == KW_INT) ? TK_INT
                                  : (kw_state == KW_IF) ? TK_IF : TK_IDENT;
                    MODE_NUM:   k = TK_NUMBER;
                    default:    k = TK_ASSIGN;
                endcase
                found.push_back(make_tok(k, pend_start, pend_len, pend_char));
                lex_mode = MODE_IDLE;
                kw_state = KW_NONE;
            end
            if (is_end) begin
                found.push_back(make_tok(TK_END, byte_pos, 8'd0, 8'd0));
            end else if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            end else if (alpha_c(ch) || digit_c(ch) || ch == CH_EQ) begin
                lex_mode   = alpha_c(ch) ? MODE_IDENT : digit_c(ch) ? MODE_NUM : MODE_EQ;
                kw_state   = (alpha_c(ch) && ch == CH_I) ? KW_I : KW_NONE;
                pend_start = byte_pos;
                pend_len   = 8'd1;
                pend_char  = ch;
            end else begin
                case (ch)
                    CH_PLUS:   k = TK_PLUS;
                    CH_MINUS:  k = TK_MINUS;
                    CH_SEMI:   k = TK_SEMI;
                    CH_LPAREN: k = TK_LPAREN;
                    CH_RPAREN: k = TK_RPAREN;
                    CH_LBRACE: k = TK_LBRACE;
                    CH_RBRACE: k = TK_RBRACE;
                    default:   k = TK_UNKNOWN;
                endcase
                found.push_back(make_tok(k, byte_pos, 8'd1, ch));
            end
        end
        if (!is_end) begin
            byte_pos++;
        end
        if (found.size() > 0) begin
            found[found.size() - 1].last_of_run = 1'b1;
        end
        foreach (found[i]) begin
            tokens_due.push_back(found[i]);
        end
    endtask

    task automatic add_byte(input logic [7:0] c);
        source.push_back('{is_end: 1'b0, ch: c});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    task automatic add_end();
        source.push_back('{is_end: 1'b1, ch: 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] rand_letter();
        return $urandom_range(0, 1) ? 8'(CH_LO_A + $urandom_range(0, 25))
                                    : 8'(CH_UP_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        return $urandom_range(0, 3) == 0 ? 8'(CH_0 + $urandom_range(0, 9)) : rand_letter();
    endfunction

    task automatic add_long(input int n, input bit ident);
        for (int i = 0; i < n; i++) begin
            if (!ident) begin
                add_byte(8'(CH_0 + $urandom_range(0, 9)));
            end else begin
                add_byte(i == 0 ? CH_I : i == 1 ? CH_N : i == 2 ? CH_T : rand_alnum());
            end
        end
        add_byte(CH_SPACE);
    endtask

    task automatic add_piece();
        int n;
        case ($urandom_range(0, 11))
            0: begin
                case ($urandom_range(0, 7))
                    0: add_text("int");
                    1: add_text("if");
                    2: add_text("in");
                    3: add_text("i");
                    4: add_text("intx");
                    5: add_text("if0");
                    6: add_text("Int");
                    default: add_text("IF");
                endcase
            end
            1, 2: begin
                n = $urandom_range(0, 7);
                add_byte(rand_letter());
                repeat (n) add_byte(rand_alnum());
            end
            3, 4: begin
                n = $urandom_range(1, 6);
                repeat (n) add_byte(8'(CH_0 + $urandom_range(0, 9)));
            end
            5: begin
                add_byte(CH_EQ);
                if ($urandom_range(0, 1)) begin
                    add_byte(CH_EQ);
                end
            end
            6, 7: begin
                case ($urandom_range(0, 6))
                    0: add_byte(CH_PLUS);
                    1: add_byte(CH_MINUS);
                    2: add_byte(CH_SEMI);
                    3: add_byte(CH_LPAREN);
                    4: add_byte(CH_RPAREN);
                    5: add_byte(CH_LBRACE);
                    default: add_byte(CH_RBRACE);
                endcase
            end
            8, 9: begin
                n = $urandom_range(1, 3);
                repeat (n) add_byte($urandom_range(0, 6) == 0 ? CH_SPACE
                                    : 8'(CH_TAB + $urandom_range(0, 4)));
            end
            10: add_byte(8'($urandom_range(0, 255)));
            default: begin
                if ($urandom_range(0, 2) == 0) begin
                    add_end();
                end else begin
                    add_byte(8'($urandom_range(128, 255)));
                end
            end
        endcase
        if ($urandom_range(0, 1)) begin
            add_byte(CH_SPACE);
        end
    endtask

    task automatic cmp_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $display("%0t: token %0d %s mismatch: expected %0d, actual %0d",
                     $time, tokens_checked, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_byte(s_func, s_input_char);
                items_sent++;
                if (s_func) begin
                    ends_sent++;
                end
            end
            if (!s_valid || s_ready) begin
                if (source.size() > 0 && ((items_sent >= 300 && items_sent < 600)
                                          || $urandom_range(0, 99) >= 38)) begin
                    nxt = source.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= nxt.is_end;
                    s_input_char <= nxt.ch;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                tokens_checked++;
                if (m_token_kind <= TK_UNKNOWN) begin
                    kinds_seen[m_token_kind] = 1'b1;
                end
                if (tokens_due.size() == 0) begin
                    $display("%0t: unexpected token: expected none, actual kind %0d start %0d",
                             $time, m_token_kind, m_token_start);
                    errors++;
                end else begin
                    want = tokens_due.pop_front();
                    cmp_field("kind", want.kind, m_token_kind);
                    cmp_field("start", want.start, m_token_start);
                    cmp_field("length", want.length, m_token_length);
                    cmp_field("char", want.last_char, m_token_char);
                    cmp_field("last_of_run", want.last_of_run, m_last_of_run);
                end
            end
            // hold off once so the result queue fills and the input stalls
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && tokens_checked >= 700) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (tokens_checked >= 300 && tokens_checked < 500)
                           || $urandom_range(0, 99) >= 38;
            end
        end
    end

    initial begin
        add_text("int if=a1==42+-;(){}");
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h0B);
        add_byte(8'h40);
        add_end();
        add_end();
        for (int p = 0; source.size() < SOURCE_ITEMS; p++) begin
            if (p == 200) begin
                add_long(260, 1'b1);
            end else if (p == 400) begin
                add_long(257, 1'b0);
            end else begin
                add_piece();
            end
        end
        add_text("x=");
        add_end();

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (source.size() > 0 || s_valid || tokens_due.size() > 0) begin
            @(negedge aclk);
        end
        repeat (16) @(posedge aclk);

        $display("Summary: %0d source items in (%0d end marks), %0d tokens checked",
                 items_sent, ends_sent, tokens_checked);
        $display("Summary: %0d of 15 token kinds seen, overlong tokens and stall included",
                 $countones(kinds_seen));
        if (errors == 0) begin
            $display("char_stream_tokenizer verification clean");
        end else begin
            $display("char_stream_tokenizer verification failed");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("Timeout with %0d tokens still due", tokens_due.size());
        $display("char_stream_tokenizer verification failed");
        $finish;
    end

endmodule
